@@ sv/oqte_pkg.sv @@
package oqte_pkg;

  // default sizes of the queue
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths of the stream payloads
  localparam int VAL_W   = 32;
  localparam int POS_W   = 5;
  localparam int ENT_W   = 5;
  localparam int CODE_W  = 3;

  // slave tdata: data_value, position, zero padding
  localparam int POS_LSB   = VAL_W;
  localparam int S_TDATA_W = 40;

  // master tdata: result_value, max_value, avg_value, entries_now, zero padding
  localparam int MAX_LSB   = VAL_W;
  localparam int AVG_LSB   = 2 * VAL_W;
  localparam int ENT_LSB   = 3 * VAL_W;
  localparam int M_TDATA_W = 104;
  localparam int M_PAD_W   = M_TDATA_W - ENT_LSB - ENT_W;

  // request kinds carried in slave tuser
  typedef enum logic [CODE_W-1:0] {
    REQ_APPEND = 3'd0,
    REQ_POP    = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_STATS  = 3'd4
  } req_t;

  // result status carried in master tuser
  typedef enum logic [CODE_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_POS   = 3'd4
  } status_t;

endpackage

@@ sv/ordered_queue_table_engine.sv @@
// Ordered queue of up to DEPTH signed entries, head at position 0, one request
// per transaction. The request arrives on the slave stream: tuser carries the
// request kind (append, pop, insert, remove, statistics), tdata the value and
// the insertion position. Each request gives exactly one result transaction on
// the master stream: tuser carries the status, tdata the popped value or the
// minimum, the maximum, the truncated average and the entry count afterwards.
// The entries live in one memory with a registered read port; every request
// is worked out by a sequencer, which walks that memory one entry per cycle
// for pop, remove, insert and statistics. Pop and remove search, then shift
// the rest down; insert shifts up, then writes the new entry; statistics
// walk the entries, then run a one bit per cycle divider. Append, rejected
// and empty requests go straight to the result.
// One request is in work at a time; the next is accepted once the result sits
// in the output register, even while the receiver has not taken it. A stalled
// receiver holds the result there and a finished request waits for it.
// Reset empties the queue and drops any result not yet taken; memory contents
// are not cleared, entries are only read after they have been written.
module ordered_queue_table_engine #(
  parameter int DEPTH      = oqte_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = oqte_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // data_value[31:0], position[36:32], zero padding
  input  logic [oqte_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // req_type[2:0]
  input  logic [oqte_pkg::CODE_W-1:0]    s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // result_value[31:0], max_value[63:32], avg_value[95:64], entries_now[100:96],
  // zero padding
  output logic [oqte_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // status[2:0]
  output logic [oqte_pkg::CODE_W-1:0]    m_axis_tuser
);
  import oqte_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int SUM_W  = DATA_WIDTH + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_DN,
    S_SHIFT_UP,
    S_DIV,
    S_EMIT
  } state_t;

  state_t state;

  // queue state
  logic [CNT_W-1:0] count;

  // request in work
  req_t                   op_req;
  logic [DATA_WIDTH-1:0]  op_val;
  logic [CNT_W-1:0]       op_pos;

  // walk pointer and the read in flight
  logic [CNT_W-1:0] idx;
  logic             pend;
  logic [CNT_W-1:0] pend_idx;

  // statistics accumulators
  logic signed [SUM_W-1:0]      sum;
  logic signed [DATA_WIDTH-1:0] mn;
  logic signed [DATA_WIDTH-1:0] mx;

  // divider
  logic [SUM_W-1:0]  dq;
  logic [CNT_W-1:0]  rem;
  logic [DCNT_W-1:0] dcnt;
  logic              neg;

  // result being built
  status_t                      r_status;
  logic signed [DATA_WIDTH-1:0] r_res;
  logic signed [DATA_WIDTH-1:0] r_max;
  logic signed [DATA_WIDTH-1:0] r_avg;

  // entry memory
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [ADDR_W-1:0]     mem_raddr;

  // input decode
  logic                  in_acc;
  req_t                  in_req;
  logic [DATA_WIDTH-1:0] in_val;
  logic [POS_W-1:0]      in_pos;
  logic                  full;
  logic                  empty;
  logic                  out_free;

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_req        = req_t'(s_axis_tuser);
  assign in_val        = s_axis_tdata[DATA_WIDTH-1:0];
  assign in_pos        = s_axis_tdata[POS_LSB +: POS_W];
  assign full          = (count == CNT_W'(DEPTH));
  assign empty         = (count == '0);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // per-entry arithmetic on the returning read
  logic signed [DATA_WIDTH-1:0] rd_s;
  logic                         first;
  logic                         last;
  logic                         match;
  logic signed [SUM_W-1:0]      sum_acc;
  logic signed [DATA_WIDTH-1:0] mn_acc;
  logic signed [DATA_WIDTH-1:0] mx_acc;
  logic [SUM_W-1:0]             sum_mag;

  assign rd_s    = rd_data;
  assign first   = (pend_idx == '0);
  assign last    = (pend_idx == CNT_W'(count - 1'b1));
  assign match   = (op_req == REQ_POP) || (rd_data == op_val);
  assign sum_acc = (first ? SUM_W'(0) : sum) + SUM_W'(rd_s);
  assign mn_acc  = (first || rd_s < mn) ? rd_s : mn;
  assign mx_acc  = (first || rd_s > mx) ? rd_s : mx;
  assign sum_mag = sum_acc[SUM_W-1] ? SUM_W'(-sum_acc) : SUM_W'(sum_acc);

  // restoring divide step
  logic [CNT_W:0]        shifted;
  logic                  qbit;
  logic [SUM_W-1:0]      q_next;
  logic [DATA_WIDTH-1:0] q_low;

  assign shifted = {rem, dq[SUM_W-1]};
  assign qbit    = (shifted >= (CNT_W + 1)'(count));
  assign q_next  = {dq[SUM_W-2:0], qbit};
  assign q_low   = q_next[DATA_WIDTH-1:0];

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = op_val;
    mem_raddr = ADDR_W'(idx);
    case (state)
      S_IDLE: begin
        if (in_acc && in_req == REQ_APPEND && !full) begin
          mem_we    = 1'b1;
          mem_waddr = ADDR_W'(count);
          mem_wdata = in_val;
        end
      end
      S_SHIFT_DN: begin
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = ADDR_W'(pend_idx - 1'b1);
          mem_wdata = rd_data;
        end
      end
      S_SHIFT_UP: begin
        mem_raddr = ADDR_W'(idx - 1'b1);
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = ADDR_W'(pend_idx + 1'b1);
          mem_wdata = rd_data;
        end else if (idx == op_pos) begin
          mem_we    = 1'b1;
          mem_waddr = ADDR_W'(op_pos);
          mem_wdata = op_val;
        end
      end
      default: begin
      end
    endcase
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      pend          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            op_req   <= in_req;
            op_val   <= in_val;
            op_pos   <= CNT_W'(in_pos);
            r_status <= ST_OK;
            r_res    <= '0;
            r_max    <= '0;
            r_avg    <= '0;
            idx      <= '0;
            pend     <= 1'b0;
            state    <= S_EMIT;
            case (in_req)
              REQ_APPEND: begin
                if (full) begin
                  r_status <= ST_FULL;
                end else begin
                  count <= CNT_W'(count + 1'b1);
                end
              end
              REQ_POP, REQ_REMOVE, REQ_STATS: begin
                if (empty) begin
                  r_status <= ST_EMPTY;
                end else begin
                  state <= S_SCAN;
                end
              end
              REQ_INSERT: begin
                if (CMP_W'(in_pos) > CMP_W'(count)) begin
                  r_status <= ST_BAD_POS;
                end else if (full) begin
                  r_status <= ST_FULL;
                end else begin
                  idx   <= count;
                  state <= S_SHIFT_UP;
                end
              end
              default: begin
                r_status <= ST_BAD_POS;
              end
            endcase
          end
        end

        // read entries in order, search or accumulate as they come back
        S_SCAN: begin
          pend     <= (idx < count);
          pend_idx <= idx;
          if (idx < count) begin
            idx <= CNT_W'(idx + 1'b1);
          end
          if (pend) begin
            if (op_req == REQ_STATS) begin
              sum <= sum_acc;
              mn  <= mn_acc;
              mx  <= mx_acc;
              if (last) begin
                r_res <= mn_acc;
                r_max <= mx_acc;
                neg   <= sum_acc[SUM_W-1];
                dq    <= sum_mag;
                rem   <= '0;
                dcnt  <= DCNT_W'(SUM_W);
                pend  <= 1'b0;
                state <= S_DIV;
              end
            end else if (match) begin
              if (op_req == REQ_POP) begin
                r_res <= rd_s;
              end
              idx   <= CNT_W'(pend_idx + 1'b1);
              pend  <= 1'b0;
              state <= S_SHIFT_DN;
            end else if (last) begin
              r_status <= ST_NOT_FOUND;
              pend     <= 1'b0;
              state    <= S_EMIT;
            end
          end
        end

        // move later entries one place toward the head
        S_SHIFT_DN: begin
          pend     <= (idx < count);
          pend_idx <= idx;
          if (idx < count) begin
            idx <= CNT_W'(idx + 1'b1);
          end else if (!pend) begin
            count <= CNT_W'(count - 1'b1);
            state <= S_EMIT;
          end
        end

        // move entries from the tail down to the position one place up
        S_SHIFT_UP: begin
          pend     <= (idx > op_pos);
          pend_idx <= CNT_W'(idx - 1'b1);
          if (idx > op_pos) begin
            idx <= CNT_W'(idx - 1'b1);
          end else if (!pend) begin
            count <= CNT_W'(count + 1'b1);
            state <= S_EMIT;
          end
        end

        // one quotient bit per cycle, sign restored at the end
        S_DIV: begin
          rem  <= qbit ? CNT_W'(shifted - (CNT_W + 1)'(count)) : CNT_W'(shifted);
          dq   <= q_next;
          dcnt <= DCNT_W'(dcnt - 1'b1);
          if (dcnt == DCNT_W'(1)) begin
            r_avg <= neg ? DATA_WIDTH'(-q_low) : q_low;
            state <= S_EMIT;
          end
        end

        // hand the result to the output register once it is free
        S_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output payload, loaded with the result
  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      m_axis_tuser <= r_status;
      m_axis_tdata <= {M_PAD_W'(0), ENT_W'(count), VAL_W'(r_avg), VAL_W'(r_max),
                       VAL_W'(r_res)};
    end
  end

  // the entry count never passes the capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // every accepted transaction starts work or a result
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state != S_IDLE)
    else $error("accepted transaction dropped");

  // memory writes stay at or below the entry count and inside the memory
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (CNT_W'(mem_waddr) <= count) && (CNT_W'(mem_waddr) < CNT_W'(DEPTH)))
    else $error("memory write outside the queue");

  // the idle state only writes memory for an accepted append
  a_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && mem_we) |-> in_acc && in_req == REQ_APPEND)
    else $error("unexpected memory write while idle");

endmodule
